// ===== design/sidec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sidec_pkg;

  localparam int unsigned BinWidth   = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CharWidth  = 7;
  localparam int unsigned BitCntW    = $clog2(BinWidth);
  localparam int unsigned DigCntW    = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0] CharZero  = 7'd48;
  localparam logic [CharWidth-1:0] CharMinus = 7'd45;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StDigits
  } sidec_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv;
    logic shift;
    logic sel_minus;
  } sidec_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic top_zero;
    logic neg;
  } sidec_status_t;

endpackage
`default_nettype wire

// ===== design/signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata[31:0] value (signed)
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata[6:0] char_code, tlast last
//
// one word at a time: the input is taken only when the previous text is fully sent
// each word: accept, 32 double-dabble steps, (10 - digits) zero-skip steps and a final
// skip check, then one character per cycle while m_axis_tready_i is high
// the 32-step shift-and-add-3 loop is the longest part of the conversion
// rst_ni is asynchronous, active low, and returns the controller to idle
// a stalled output word holds its data until taken
module signed_int_to_decimal_ascii_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [6:0] char_code, [7] zero
  output logic             m_axis_tlast_o
);

  sidec_pkg::sidec_cmd_t              cmd;
  sidec_pkg::sidec_status_t           status;
  logic [sidec_pkg::CharWidth-1:0]    char_code;

  sidec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_last_o  (m_axis_tlast_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  sidec_dp u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .value_i  (s_axis_tdata_i),
    .status_o (status),
    .char_o   (char_code)
  );

  assign m_axis_tdata_o = {1'b0, char_code};

  // input and output sides never active together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while output valid");

  // the last character is always a digit
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tdata_o[6:0] != sidec_pkg::CharMinus))
    else $error("last word is not a digit");

  // conversion takes time: no output right after an accepted input
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !m_axis_tvalid_o)
    else $error("output valid right after input");

endmodule
`default_nettype wire

// ===== design/sidec_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sidec_dp (
  input  wire logic                             clk_i,
  input  wire sidec_pkg::sidec_cmd_t            cmd_i,
  input  wire logic [sidec_pkg::BinWidth-1:0]   value_i,
  output sidec_pkg::sidec_status_t              status_o,
  output logic [sidec_pkg::CharWidth-1:0]       char_o
);

  logic [sidec_pkg::BinWidth-1:0] bin_q, bin_d;
  logic [sidec_pkg::BcdWidth-1:0] bcd_q, bcd_d;
  logic                           neg_q, neg_d;
  logic [sidec_pkg::BcdWidth-1:0] adj;
  logic [3:0]                     top;

  assign top = bcd_q[sidec_pkg::BcdWidth-1 -: 4];

  // add-3 correction on every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sidec_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    if (cmd_i.load) begin
      neg_d = value_i[sidec_pkg::BinWidth-1];
      bin_d = value_i[sidec_pkg::BinWidth-1] ? (~value_i + 1'b1) : value_i;
      bcd_d = '0;
    end else if (cmd_i.conv) begin
      bin_d = {bin_q[sidec_pkg::BinWidth-2:0], 1'b0};
      bcd_d = {adj[sidec_pkg::BcdWidth-2:0], bin_q[sidec_pkg::BinWidth-1]};
    end else if (cmd_i.shift) begin
      bcd_d = {bcd_q[sidec_pkg::BcdWidth-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign status_o.top_zero = (top == 4'd0);
  assign status_o.neg      = neg_q;
  assign char_o = cmd_i.sel_minus ? sidec_pkg::CharMinus
                                  : sidec_pkg::CharZero + {3'd0, top};

endmodule
`default_nettype wire

// ===== design/sidec_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sidec_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           out_last_o,
  output sidec_pkg::sidec_cmd_t          cmd_o,
  input  wire sidec_pkg::sidec_status_t  status_i
);

  sidec_pkg::sidec_state_e            state_q, state_d;
  logic [sidec_pkg::BitCntW-1:0]      bit_cnt_q, bit_cnt_d;
  logic [sidec_pkg::DigCntW-1:0]      dig_cnt_q, dig_cnt_d;

  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    case (state_q)
      sidec_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d   = sidec_pkg::StConv;
          bit_cnt_d = sidec_pkg::BitCntW'(sidec_pkg::BinWidth - 1);
          dig_cnt_d = sidec_pkg::DigCntW'(sidec_pkg::NumDigits);
        end
      end
      sidec_pkg::StConv: begin
        if (bit_cnt_q == '0) begin
          state_d = sidec_pkg::StSkip;
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
        end
      end
      sidec_pkg::StSkip: begin
        // drop leading zeros, always keep the last digit
        if (status_i.top_zero && dig_cnt_q != sidec_pkg::DigCntW'(1)) begin
          dig_cnt_d = dig_cnt_q - 1'b1;
        end else begin
          state_d = status_i.neg ? sidec_pkg::StSign : sidec_pkg::StDigits;
        end
      end
      sidec_pkg::StSign: begin
        if (out_ready_i) begin
          state_d = sidec_pkg::StDigits;
        end
      end
      sidec_pkg::StDigits: begin
        if (out_ready_i) begin
          dig_cnt_d = dig_cnt_q - 1'b1;
          if (dig_cnt_q == sidec_pkg::DigCntW'(1)) begin
            state_d = sidec_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = sidec_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    out_last_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      sidec_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sidec_pkg::StConv: begin
        cmd_o.conv = 1'b1;
      end
      sidec_pkg::StSkip: begin
        cmd_o.shift = status_i.top_zero && dig_cnt_q != sidec_pkg::DigCntW'(1);
      end
      sidec_pkg::StSign: begin
        out_valid_o     = 1'b1;
        cmd_o.sel_minus = 1'b1;
      end
      sidec_pkg::StDigits: begin
        out_valid_o = 1'b1;
        out_last_o  = (dig_cnt_q == sidec_pkg::DigCntW'(1));
        cmd_o.shift = out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sidec_pkg::StIdle;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/signed_int_to_decimal_ascii_core_test.sv =====
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_core_test;

  localparam int ClkHalf    = 6;
  localparam int StallLimit = 4000;
  localparam int RandPerPhase = 47;

  typedef struct packed {
    logic [sidec_pkg::CharWidth-1:0] code;
    logic                            last;
  } text_char_t;

  typedef enum int {
    PaceFree,
    PaceSrcGaps,
    PaceSinkStalls,
    PaceBoth
  } pace_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] value
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // [6:0] char_code, [7] zero
  logic        m_axis_tlast_o;

  logic [31:0] value_q[$];
  text_char_t  text_q[$];
  pace_e       pace;
  logic        in_taken;
  int          mismatches;
  int          quiet_cycles;

  signed_int_to_decimal_ascii_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // decimal text of one value, sign first, most significant digit next
  task automatic push_decimal_text(input logic [31:0] value);
    logic [31:0] mag;
    logic [3:0]  digits [sidec_pkg::NumDigits];
    int          ndig;
    text_char_t  ch;
    mag  = value[31] ? (~value + 32'd1) : value;
    ndig = 0;
    do begin
      digits[ndig] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      ndig++;
    end while (mag != 32'd0 && ndig < sidec_pkg::NumDigits);
    if (value[31]) begin
      ch.code = sidec_pkg::CharMinus;
      ch.last = 1'b0;
      text_q.push_back(ch);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      ch.code = sidec_pkg::CharZero + 7'(digits[i]);
      ch.last = (i == 0);
      text_q.push_back(ch);
    end
  endtask

  function automatic int gap_pct(input pace_e p, input logic sink);
    int pct;
    pct = 0;
    case (p)
      PaceSrcGaps:    pct = sink ? 0 : 45;
      PaceSinkStalls: pct = sink ? 45 : 0;
      PaceBoth:       pct = 11;
      default:        pct = 0;
    endcase
    return pct;
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    int unsigned pow10;
    int          k;
    v = 32'd0;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1, 2: begin
        k = $urandom_range(1, 9);
        pow10 = 1;
        for (int i = 0; i < k; i++) pow10 = pow10 * 10;
        v = $urandom_range(0, pow10 - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        v = $urandom_range(0, 20);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // driver: new word only once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (value_q.size() != 0 && $urandom_range(0, 99) >= gap_pct(pace, 1'b0)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= value_q.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= gap_pct(pace, 1'b1));
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    text_char_t exp_ch;
    if (rst_ni) begin
      in_taken = s_axis_tvalid_i && s_axis_tready_o;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (text_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: tdata=%h tlast=%b", m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          exp_ch = text_q.pop_front();
          if (m_axis_tdata_o !== {1'b0, exp_ch.code} || m_axis_tlast_o !== exp_ch.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("char mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                       {1'b0, exp_ch.code}, exp_ch.last, m_axis_tdata_o, m_axis_tlast_o);
          end
        end
      end
      if (in_taken) push_decimal_text(s_axis_tdata_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] directed [] = '{
      32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100, -32'd7, 32'd42,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
      32'd1000000000, 32'd999999999, -32'd999999999, 32'd1234567890,
      32'h5555_5555, 32'hAAAA_AAAA, -32'd1000000000, 32'd100000
    };
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 32'd0;
    m_axis_tready_i = 1'b0;
    in_taken        = 1'b0;
    mismatches      = 0;
    quiet_cycles    = 0;
    pace            = PaceFree;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < 4; p++) begin
      pace = pace_e'(p);
      if (p == 0)
        foreach (directed[i]) value_q.push_back(directed[i]);
      for (int i = 0; i < RandPerPhase; i++) value_q.push_back(random_value());
      do @(posedge clk_i); while (value_q.size() != 0 || s_axis_tvalid_i);
    end

    while (text_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && text_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sidec_pkg.sv
design/sidec_dp.sv
design/sidec_ctrl.sv
design/signed_int_to_decimal_ascii_core.sv
tb/sv/signed_int_to_decimal_ascii_core_test.sv
